>>> src/jtbc_pkg.sv
`default_nettype none

package jtbc_pkg;

  // Region and map geometry.
  localparam int unsigned CODE_BYTES       = 65536;
  localparam int unsigned TRAMPOLINE_ALIGN = 32;
  localparam int unsigned MAP_DEPTH        = CODE_BYTES / 8;
  localparam int unsigned IDX_W            = $clog2(MAP_DEPTH);
  localparam int unsigned OFF_W            = $clog2(CODE_BYTES);
  localparam int unsigned RS_W             = OFF_W + 1;
  localparam int unsigned TA_W             = $clog2(TRAMPOLINE_ALIGN);

  // Item opcodes.
  localparam logic [1:0] OP_INST  = 2'd0;
  localparam logic [1:0] OP_JUMP  = 2'd1;
  localparam logic [1:0] OP_MARK  = 2'd2;
  localparam logic [1:0] OP_CHECK = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BASE  = 2'd0;
  localparam logic [1:0] CFG_LIMIT = 2'd1;
  localparam logic [1:0] CFG_ALIGN = 2'd2;
  localparam logic [1:0] CFG_TRAMP = 2'd3;

  // Register values after reset.
  localparam logic [31:0] RST_BASE  = 32'h0000_0000;
  localparam logic [31:0] RST_LIMIT = 32'h0001_0000;
  localparam logic [4:0]  RST_ALIGN = 5'd31;
  localparam logic [31:0] RST_TRAMP = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] inst_pc;
    logic [3:0]  inst_length;
    logic        is_call;
    logic        has_target;
    logic [31:0] target_address;
    logic [12:0] group_index;
  } in_item_t;

  typedef struct packed {
    logic       pc_out_of_range;
    logic       jump_bad;
    logic       call_misaligned;
    logic [7:0] bad_target_mask;
    logic       block_start_missing;
    logic       base_misaligned;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             load;
    logic             calc;
    logic             read;
    logic             exec;
    logic             clear;
    logic [IDX_W-1:0] clear_idx;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

>>> src/jump_target_bitmap_checker_unit.sv
// A result is offered once its item has passed the calc, read and exec steps, later if an older result waits.
// No new item is taken until the previous one has finished the read-modify-write of the map memories.
// Reset (rst_ni, asynchronous, active low) restores the configuration registers and starts
// a clearing sweep of both bitmaps, one entry per cycle over all 8192 (MAP_DEPTH) entries,
// during which no item is taken; configuration writes are taken at any time.
`default_nettype none

module jump_target_bitmap_checker_unit (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // Configuration write port.
  input  wire logic              cfg_we_i,
  input  wire logic [1:0]        cfg_idx_i,
  input  wire logic [31:0]       cfg_data_i,
  // Item input channel.
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  jtbc_pkg::in_item_t     in_data_i,
  // Result output channel.
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output jtbc_pkg::out_item_t    out_data_o
);

  // The controller sequences each item through three steps after its transfer.
  // The first step forms the offsets of the instruction address, the target and
  // the limit from the base, and the low end of the trampoline window. The
  // second step settles the region and target decisions and reads one byte from
  // each bitmap. The third step writes the modified bytes back and loads the
  // result register.
  //
  // The result register sits between the two channels, so a new item is taken
  // while the previous result still waits for its transfer. Only the final
  // step stalls when that register is still occupied.
  jtbc_pkg::ctrl_cmd_t cmd;

  jtbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // The datapath holds the configuration registers, both bitmaps and the
  // result register. Since only one item is in flight and its write-back
  // completes before the next item reads, no forwarding is required.
  jtbc_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

>>> src/jtbc_ctrl.sv
`default_nettype none

module jtbc_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output jtbc_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_READ,
    ST_EXEC
  } state_e;

  state_e                      state_q;
  logic [jtbc_pkg::IDX_W-1:0]  clr_q;
  logic                        out_valid_q;
  logic                        exec_fire;

  // The final step waits while a finished result has not been taken.
  assign exec_fire = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == jtbc_pkg::IDX_W'(jtbc_pkg::MAP_DEPTH - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_CALC;
          end
        end
        ST_CALC: state_q <= ST_READ;
        ST_READ: state_q <= ST_EXEC;
        ST_EXEC: begin
          if (exec_fire) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase

      if (exec_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.calc      = (state_q == ST_CALC);
    cmd_o.read      = (state_q == ST_READ);
    cmd_o.exec      = exec_fire;
    cmd_o.clear     = (state_q == ST_CLEAR);
    cmd_o.clear_idx = clr_q;
  end

endmodule

`default_nettype wire

>>> src/jtbc_datapath.sv
`default_nettype none

module jtbc_datapath (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_idx_i,
  input  wire logic [31:0]          cfg_data_i,
  input  jtbc_pkg::in_item_t        in_data_i,
  input  jtbc_pkg::ctrl_cmd_t       cmd_i,
  output jtbc_pkg::out_item_t       out_data_o
);

  localparam int unsigned IW = jtbc_pkg::IDX_W;

  // Configuration registers.
  logic [31:0] base_q, limit_q, tramp_q;
  logic [4:0]  align_q;

  // Current item.
  jtbc_pkg::in_item_t item_q;

  // First stage: differences and limit compares.
  logic [32:0] pc_off_q, t_off_q, lim_off_q, low_q;
  logic        pc_lt_lim_q, t_lt_lim_q;

  // Second stage: region decisions and map reads.
  logic            pc_in_q, t_bad_q, t_rec_q;
  logic [jtbc_pkg::RS_W-1:0] rs_q;
  logic [IW-1:0]   s_idx_q, t_idx_q;
  logic [2:0]      s_bit_q, t_bit_q;
  logic [IW-1:0]   s_ridx, t_ridx;
  logic [31:0]     low;
  logic            t_lt_base, tramp_ok, t_in, t_bad;
  logic [jtbc_pkg::RS_W-1:0] rs;

  // Bitmaps.
  logic [7:0] start_mem [jtbc_pkg::MAP_DEPTH];
  logic [7:0] tgt_mem   [jtbc_pkg::MAP_DEPTH];
  logic [7:0] s_rd_q, t_rd_q;

  // Final stage.
  logic [7:0]          s_mask, t_mask, s_wdata, t_wdata;
  logic                s_we, t_we;
  logic [IW-1:0]       s_waddr, t_waddr;
  logic [4:0]          ret_low, a_low;
  logic                misaligned, in_grp;
  logic [15:0]         grp_off;
  jtbc_pkg::out_item_t res;
  jtbc_pkg::out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= jtbc_pkg::RST_BASE;
      limit_q <= jtbc_pkg::RST_LIMIT;
      align_q <= jtbc_pkg::RST_ALIGN;
      tramp_q <= jtbc_pkg::RST_TRAMP;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        jtbc_pkg::CFG_BASE:  base_q  <= cfg_data_i;
        jtbc_pkg::CFG_LIMIT: limit_q <= cfg_data_i;
        jtbc_pkg::CFG_ALIGN: align_q <= cfg_data_i[4:0];
        jtbc_pkg::CFG_TRAMP: tramp_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
    if (cmd_i.calc) begin
      pc_off_q    <= {1'b0, item_q.inst_pc} - {1'b0, base_q};
      t_off_q     <= {1'b0, item_q.target_address} - {1'b0, base_q};
      lim_off_q   <= {1'b0, limit_q} - {1'b0, base_q};
      low_q       <= {1'b0, base_q} - {1'b0, tramp_q};
      pc_lt_lim_q <= item_q.inst_pc < limit_q;
      t_lt_lim_q  <= item_q.target_address < limit_q;
    end
  end

  // Borrow bit set means the address lies below base.
  always_comb begin
    low       = low_q[32] ? 32'd0 : low_q[31:0];
    t_lt_base = t_off_q[32];
    tramp_ok  = (item_q.target_address >= low) &&
                (item_q.target_address[jtbc_pkg::TA_W-1:0] == '0);
    t_in      = !t_lt_base && t_lt_lim_q &&
                (t_off_q[31:0] < 32'(jtbc_pkg::CODE_BYTES));
    if (!t_lt_lim_q) begin
      t_bad = 1'b1;
    end else if (t_lt_base) begin
      t_bad = !tramp_ok;
    end else begin
      t_bad = !t_in;
    end
    if (lim_off_q[32]) begin
      rs = '0;
    end else if (lim_off_q[31:0] >= 32'(jtbc_pkg::CODE_BYTES)) begin
      rs = jtbc_pkg::RS_W'(jtbc_pkg::CODE_BYTES);
    end else begin
      rs = lim_off_q[jtbc_pkg::RS_W-1:0];
    end
    if (item_q.op == jtbc_pkg::OP_CHECK) begin
      s_ridx = IW'(item_q.group_index);
      t_ridx = IW'(item_q.group_index);
    end else begin
      s_ridx = pc_off_q[jtbc_pkg::OFF_W-1:3];
      t_ridx = t_off_q[jtbc_pkg::OFF_W-1:3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      pc_in_q <= !pc_off_q[32] && pc_lt_lim_q &&
                 (pc_off_q[31:0] < 32'(jtbc_pkg::CODE_BYTES));
      t_bad_q <= t_bad;
      t_rec_q <= t_in;
      rs_q    <= rs;
      s_idx_q <= s_ridx;
      t_idx_q <= t_ridx;
      s_bit_q <= pc_off_q[2:0];
      t_bit_q <= t_off_q[2:0];
    end
  end

  // Map memories: one write and one registered read port each.
  always_ff @(posedge clk_i) begin
    if (s_we) begin
      start_mem[s_waddr] <= s_wdata;
    end
    if (cmd_i.read) begin
      s_rd_q <= start_mem[s_ridx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      tgt_mem[t_waddr] <= t_wdata;
    end
    if (cmd_i.read) begin
      t_rd_q <= tgt_mem[t_ridx];
    end
  end

  always_comb begin
    s_mask     = 8'h01 << s_bit_q;
    t_mask     = 8'h01 << t_bit_q;
    ret_low    = item_q.inst_pc[4:0] + {1'b0, item_q.inst_length};
    misaligned = (base_q[4:0] & align_q) != 5'd0;
    res        = '0;
    s_we       = 1'b0;
    t_we       = 1'b0;
    s_wdata    = s_rd_q;
    t_wdata    = t_rd_q | t_mask;
    a_low      = '0;
    in_grp     = 1'b0;
    grp_off    = '0;
    case (item_q.op)
      jtbc_pkg::OP_INST: begin
        res.pc_out_of_range = !pc_in_q;
        s_we                = pc_in_q;
        s_wdata             = s_rd_q | s_mask;
        res.jump_bad        = item_q.has_target && t_bad_q;
        t_we                = item_q.has_target && t_rec_q;
        res.call_misaligned = item_q.is_call && ((ret_low & align_q) != 5'd0);
      end
      jtbc_pkg::OP_JUMP: begin
        res.jump_bad = t_bad_q;
        t_we         = t_rec_q;
      end
      jtbc_pkg::OP_MARK: begin
        s_we    = pc_in_q;
        s_wdata = s_rd_q & ~s_mask;
      end
      default: begin
        res.base_misaligned = misaligned;
        for (int i = 0; i < 8; i++) begin
          grp_off = {item_q.group_index, 3'(i)};
          in_grp  = 32'(grp_off) < 32'(rs_q);
          a_low   = base_q[4:0] + {item_q.group_index[1:0], 3'(i)};
          res.bad_target_mask[i] = in_grp && t_rd_q[i] && !s_rd_q[i];
          if (in_grp && !misaligned && ((a_low & align_q) == 5'd0) && !s_rd_q[i]) begin
            res.block_start_missing = 1'b1;
          end
        end
      end
    endcase
    s_we = s_we && cmd_i.exec;
    t_we = t_we && cmd_i.exec;
    // The clearing sweep owns both write ports after reset.
    if (cmd_i.clear) begin
      s_we    = 1'b1;
      t_we    = 1'b1;
      s_wdata = '0;
      t_wdata = '0;
      s_waddr = cmd_i.clear_idx;
      t_waddr = cmd_i.clear_idx;
    end else begin
      s_waddr = s_idx_q;
      t_waddr = t_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q <= res;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

>>> src/jtbc_checker.sv
`default_nettype none

module jtbc_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input jtbc_pkg::out_item_t      out_data_o
);

  // A result that is not taken stays offered unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // An accepted item keeps the input closed through its calc and read steps.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input reopened while an item was in flight");

  // A new result only appears at the end of an item's processing.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an item in flight");

  // The bitmap clearing sweep follows reset, so no item is taken right away.
  a_clear_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_ready_o && !out_valid_o)
    else $error("input open or result offered right after reset");

endmodule

bind jump_target_bitmap_checker_unit jtbc_checker u_jtbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // Longest stretch without any transfer before the run is abandoned. It leaves ample
  // margin over the clearing sweep after reset, which covers all MAP_DEPTH entries.
  localparam int unsigned IDLE_LIMIT = 30000;

  // One row of the directed list. When given is set, want is the result written
  // out by hand; otherwise the result comes from the predictor.
  typedef struct packed {
    jtbc_pkg::in_item_t  item;
    logic                given;
    jtbc_pkg::out_item_t want;
  } row_t;

  typedef struct packed {
    logic                given;
    jtbc_pkg::out_item_t want;
  } note_t;

  localparam jtbc_pkg::out_item_t CLEAN = '0;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [1:0]          cfg_idx;
  logic [31:0]         cfg_data;
  logic                in_valid;
  logic                in_ready;
  jtbc_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  jtbc_pkg::out_item_t out_data;

  // Shadow copy of the configuration registers and of both bitmaps.
  bit [31:0] reg_base  = jtbc_pkg::RST_BASE;
  bit [31:0] reg_limit = jtbc_pkg::RST_LIMIT;
  bit [4:0]  reg_align = jtbc_pkg::RST_ALIGN;
  bit [31:0] reg_tramp = jtbc_pkg::RST_TRAMP;
  bit [7:0]  start_bits  [jtbc_pkg::MAP_DEPTH];
  bit [7:0]  target_bits [jtbc_pkg::MAP_DEPTH];

  jtbc_pkg::out_item_t flags_due [$];
  note_t               given_due [$];
  int unsigned bad_count = 0;
  int unsigned sent = 0;
  int unsigned quiet = 0;
  int unsigned gap_pct = 0;
  int unsigned rx_pct = 0;

  jump_target_bitmap_checker_unit u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Bytes covered by the region: zero when the limit is not above the base, and
  // never more than the bitmaps can hold.
  function automatic longint unsigned span_bytes();
    longint unsigned sz;
    if (reg_limit <= reg_base) return 0;
    sz = reg_limit - reg_base;
    return (sz > jtbc_pkg::CODE_BYTES) ? jtbc_pkg::CODE_BYTES : sz;
  endfunction

  function automatic bit in_span(longint unsigned a);
    longint unsigned off;
    if (a < reg_base) return 1'b0;
    off = a - reg_base;
    return off < span_bytes() && (off >> 3) < jtbc_pkg::MAP_DEPTH;
  endfunction

  // Judges a direct jump target and records it when it lands inside the region.
  // Targets below the base are legal only inside the trampoline window, whose low
  // end stops at zero, and only on a trampoline boundary; those are not recorded.
  function automatic bit jump_rejected(bit [31:0] t);
    bit [31:0]       low;
    longint unsigned off;
    if (t >= reg_limit) return 1'b1;
    if (t < reg_base) begin
      low = (reg_base >= reg_tramp) ? reg_base - reg_tramp : 32'h0;
      return (t < low) || (t % jtbc_pkg::TRAMPOLINE_ALIGN != 0);
    end
    if (!in_span(t)) return 1'b1;
    off = t - reg_base;
    target_bits[off[jtbc_pkg::IDX_W+2:3]][off[2:0]] = 1'b1;
    return 1'b0;
  endfunction

  function automatic jtbc_pkg::out_item_t predict_flags(jtbc_pkg::in_item_t it);
    jtbc_pkg::out_item_t          r;
    longint unsigned              a;
    longint unsigned              off;
    bit [jtbc_pkg::IDX_W-1:0]     k;
    bit [2:0]                     b;
    bit [31:0]                    ret;
    bit                           skew;
    r = '0;
    case (it.op)
      jtbc_pkg::OP_INST: begin
        if (in_span(it.inst_pc)) begin
          off = it.inst_pc - reg_base;
          start_bits[off[jtbc_pkg::IDX_W+2:3]][off[2:0]] = 1'b1;
        end else begin
          r.pc_out_of_range = 1'b1;
        end
        if (it.has_target) r.jump_bad = jump_rejected(it.target_address);
        // The return address wraps at 32 bits.
        ret = it.inst_pc + it.inst_length;
        if (it.is_call && (ret & reg_align) != 0) r.call_misaligned = 1'b1;
      end
      jtbc_pkg::OP_JUMP: begin
        r.jump_bad = jump_rejected(it.target_address);
      end
      jtbc_pkg::OP_MARK: begin
        if (in_span(it.inst_pc)) begin
          off = it.inst_pc - reg_base;
          start_bits[off[jtbc_pkg::IDX_W+2:3]][off[2:0]] = 1'b0;
        end
      end
      default: begin
        // A misaligned base switches the block start check off.
        skew = (reg_base & reg_align) != 0;
        for (int i = 0; i < 8; i++) begin
          a = longint'(reg_base) + longint'(it.group_index) * 8 + i;
          if (in_span(a)) begin
            off = a - reg_base;
            k   = off[jtbc_pkg::IDX_W+2:3];
            b   = off[2:0];
            if (target_bits[k][b] && !start_bits[k][b])
              r.bad_target_mask[i] = 1'b1;
            if (!skew && (a[31:0] & reg_align) == 0 && !start_bits[k][b])
              r.block_start_missing = 1'b1;
          end
        end
        r.base_misaligned = skew;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Scoreboard: predicts on every input transfer, checks every output transfer.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    note_t               note;
    jtbc_pkg::out_item_t want;
    jtbc_pkg::out_item_t got;
    if (rst_n && in_valid && in_ready) begin
      note = given_due.pop_front();
      want = predict_flags(in_data);
      flags_due.push_back(note.given ? note.want : want);
    end
    if (rst_n && out_valid && out_ready) begin
      got = out_data;
      if (flags_due.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("%0t: result %h arrived with nothing pending", $time, got);
      end else begin
        want = flags_due.pop_front();
        if (got.pc_out_of_range !== want.pc_out_of_range ||
            got.jump_bad !== want.jump_bad ||
            got.call_misaligned !== want.call_misaligned ||
            got.bad_target_mask !== want.bad_target_mask ||
            got.block_start_missing !== want.block_start_missing ||
            got.base_misaligned !== want.base_misaligned) begin
          bad_count++;
          if (bad_count <= 10)
            $display("%0t: bad result: expected pc=%b jump=%b call=%b targets=%h start=%b base=%b",
                     $time, want.pc_out_of_range, want.jump_bad, want.call_misaligned,
                     want.bad_target_mask, want.block_start_missing, want.base_misaligned,
                     "\n    got pc=%b jump=%b call=%b targets=%h start=%b base=%b",
                     got.pc_out_of_range, got.jump_bad, got.call_misaligned,
                     got.bad_target_mask, got.block_start_missing, got.base_misaligned);
        end
      end
    end
  end

  // Watchdog: any transfer on either channel restarts the count.
  always @(posedge clk) begin : watchdog
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet == IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stall bursts, plus one long hold-off once a few hundred
  // results have gone through so that the block backs up into its input.
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned hold;
    int unsigned seen;
    bit          held;
    hold = 0;
    seen = 0;
    held = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) seen++;
      if (!held && seen >= 400) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (90) @(posedge clk);
      end else if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (rx_pct != 0 && $urandom_range(0, 99) < rx_pct) begin
        hold = $urandom_range(1, 11) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic jtbc_pkg::in_item_t mk(logic [1:0] op, logic [31:0] pc,
                                            logic [3:0] len, logic call, logic tgt,
                                            logic [31:0] taddr, logic [12:0] grp);
    jtbc_pkg::in_item_t it;
    it.op             = op;
    it.inst_pc        = pc;
    it.inst_length    = len;
    it.is_call        = call;
    it.has_target     = tgt;
    it.target_address = taddr;
    it.group_index    = grp;
    return it;
  endfunction

  function automatic jtbc_pkg::out_item_t flags(logic pc, logic jb, logic cm,
                                                logic [7:0] btm, logic bsm, logic bm);
    jtbc_pkg::out_item_t r;
    r.pc_out_of_range     = pc;
    r.jump_bad            = jb;
    r.call_misaligned     = cm;
    r.bad_target_mask     = btm;
    r.block_start_missing = bsm;
    r.base_misaligned     = bm;
    return r;
  endfunction

  // Jump destinations spread over the interesting spots: inside a window of the
  // region, on and off trampoline boundaries below the base, around the window's
  // low end, around the limit, and anywhere at all.
  function automatic bit [31:0] aim(bit [31:0] win);
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return reg_base - jtbc_pkg::TRAMPOLINE_ALIGN * $urandom_range(0, 12);
      2: return reg_base - $urandom_range(1, 40);
      3: return reg_base - reg_tramp -
                ($urandom_range(0, 1) ? jtbc_pkg::TRAMPOLINE_ALIGN : 0);
      4: return reg_limit + $urandom_range(0, 3) - 2;
      default: return win + $urandom_range(0, 39);
    endcase
  endfunction

  function automatic jtbc_pkg::in_item_t noise();
    jtbc_pkg::in_item_t it;
    it.op             = 2'($urandom_range(0, 3));
    it.inst_pc        = $urandom_range(0, 1) ? $urandom() : reg_base + $urandom_range(0, 300);
    it.inst_length    = 4'($urandom_range(1, 15));
    it.is_call        = 1'($urandom_range(0, 1));
    it.has_target     = 1'($urandom_range(0, 1));
    it.target_address = aim(reg_base + $urandom_range(0, 300));
    it.group_index    = 13'($urandom_range(0, 1) ? $urandom_range(0, 8191)
                                                 : $urandom_range(0, 40));
    return it;
  endfunction

  // Offers one item and returns at the edge where it is taken. An optional idle
  // burst comes first; valid then stays high until the transfer.
  task automatic send_item(input jtbc_pkg::in_item_t item, input logic given,
                           input jtbc_pkg::out_item_t want);
    int unsigned gap;
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    given_due.push_back({given, want});
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (flags_due.size() != 0);
  endtask

  // A well-formed burst: a run of instructions decoded back to back through one
  // window, with jumps and the odd mark mixed in, followed by checks of the
  // groups that cover the window.
  task automatic run_bundle();
    longint unsigned    sz;
    int unsigned        wmax;
    int unsigned        n;
    int unsigned        pick;
    bit [31:0]          win;
    bit [31:0]          pc;
    jtbc_pkg::in_item_t it;
    sz   = span_bytes();
    wmax = (sz >= 64) ? int'((sz > 2048 ? 64'd2048 : sz) / 32) - 1 : 0;
    win  = reg_base + 32 * $urandom_range(0, wmax);
    pc   = win;
    n    = $urandom_range(2, 8);
    repeat (n) begin
      it   = noise();
      pick = $urandom_range(0, 9);
      it.op = (pick < 6) ? jtbc_pkg::OP_INST : (pick < 8) ? jtbc_pkg::OP_JUMP
                                                           : jtbc_pkg::OP_MARK;
      it.inst_pc = (it.op == jtbc_pkg::OP_MARK) ? win + $urandom_range(0, 31) : pc;
      it.target_address = aim(win);
      it.is_call = ($urandom_range(0, 3) == 0);
      send_item(it, 1'b0, CLEAN);
      if (it.op == jtbc_pkg::OP_INST) pc += it.inst_length;
    end
    for (int g = 0; g < 5; g++) begin
      it = noise();
      it.op = jtbc_pkg::OP_CHECK;
      it.group_index = 13'((win - reg_base) >> 3) + 13'(g);
      send_item(it, 1'b0, CLEAN);
    end
  endtask

  // One phase: wait until the block is idle, load all four registers, then run
  // random traffic under the given idling rates.
  task automatic run_phase(input bit [31:0] b, input bit [31:0] l, input bit [4:0] a,
                           input bit [31:0] t, input int unsigned quota,
                           input int unsigned gap, input int unsigned rx);
    int unsigned first;
    drain();
    cfg_we   <= 1'b1;
    cfg_idx  <= jtbc_pkg::CFG_BASE;
    cfg_data <= b;
    @(posedge clk);
    reg_base = b;
    cfg_idx  <= jtbc_pkg::CFG_LIMIT;
    cfg_data <= l;
    @(posedge clk);
    reg_limit = l;
    // Only the low five bits of the alignment register matter.
    cfg_idx  <= jtbc_pkg::CFG_ALIGN;
    cfg_data <= {27'($urandom()), a};
    @(posedge clk);
    reg_align = a;
    cfg_idx  <= jtbc_pkg::CFG_TRAMP;
    cfg_data <= t;
    @(posedge clk);
    reg_tramp = t;
    cfg_we   <= 1'b0;
    gap_pct = gap;
    rx_pct  = rx;
    first   = sent;
    while (sent - first < quota) begin
      if ($urandom_range(0, 3) != 0) send_item(noise(), 1'b0, CLEAN);
      else run_bundle();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    row_t plan [$];
    rst_n    = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = jtbc_pkg::CFG_BASE;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data  = '0;

    // Directed rows run under the reset configuration: region 0 to 64 KiB,
    // 32-byte bundles, trampoline window empty since the base is zero.
    plan.push_back({mk(jtbc_pkg::OP_CHECK, 32'h0, 4'd1, 1'b0, 1'b0, 32'h0, 13'd0),
                    1'b1, flags(1'b0, 1'b0, 1'b0, 8'h00, 1'b1, 1'b0)});
    plan.push_back({mk(jtbc_pkg::OP_INST, 32'h0, 4'd1, 1'b0, 1'b0, 32'h0, 13'd0),
                    1'b1, CLEAN});
    // Everything at its top value: out of range, target past the limit, and the
    // return address wraps to a misaligned value.
    plan.push_back({mk(jtbc_pkg::OP_INST, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b1,
                       32'hFFFF_FFFF, 13'h1FFF),
                    1'b1, flags(1'b1, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0)});
    plan.push_back({mk(jtbc_pkg::OP_INST, 32'h1B, 4'd5, 1'b1, 1'b1, 32'h40, 13'd0),
                    1'b0, CLEAN});
    plan.push_back({mk(jtbc_pkg::OP_JUMP, 32'h0, 4'd1, 1'b0, 1'b0, 32'h41, 13'd0),
                    1'b0, CLEAN});
    plan.push_back({mk(jtbc_pkg::OP_JUMP, 32'h0, 4'd1, 1'b0, 1'b0, 32'h0001_0000, 13'd0),
                    1'b1, flags(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0)});
    plan.push_back({mk(jtbc_pkg::OP_JUMP, 32'h0, 4'd1, 1'b0, 1'b0, 32'h0, 13'd0),
                    1'b0, CLEAN});
    plan.push_back({mk(jtbc_pkg::OP_CHECK, 32'h0, 4'd1, 1'b0, 1'b0, 32'h0, 13'd8),
                    1'b0, CLEAN});
    plan.push_back({mk(jtbc_pkg::OP_CHECK, 32'h0, 4'd1, 1'b0, 1'b0, 32'h0, 13'd0),
                    1'b0, CLEAN});
    plan.push_back({mk(jtbc_pkg::OP_MARK, 32'h0, 4'd1, 1'b0, 1'b0, 32'h0, 13'd0),
                    1'b1, CLEAN});
    plan.push_back({mk(jtbc_pkg::OP_CHECK, 32'h0, 4'd1, 1'b0, 1'b0, 32'h0, 13'd0),
                    1'b0, CLEAN});
    // A mark outside the region is dropped without a flag.
    plan.push_back({mk(jtbc_pkg::OP_MARK, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b1,
                       32'hFFFF_FFFF, 13'h1FFF),
                    1'b1, CLEAN});
    plan.push_back({mk(jtbc_pkg::OP_CHECK, 32'h0, 4'd1, 1'b0, 1'b0, 32'h0, 13'h1FFF),
                    1'b0, CLEAN});
    // No target carried: the garbage address must not raise a jump flag.
    plan.push_back({mk(jtbc_pkg::OP_INST, 32'h20, 4'd3, 1'b1, 1'b0, 32'hFFFF_FFFF, 13'd0),
                    1'b0, CLEAN});
    plan.push_back({mk(jtbc_pkg::OP_INST, 32'hFFFF, 4'd1, 1'b1, 1'b1, 32'hFFFF, 13'd0),
                    1'b0, CLEAN});
    plan.push_back({mk(jtbc_pkg::OP_JUMP, 32'hFFFF_FFFF, 4'd15, 1'b1, 1'b1,
                       32'hFFFF_FFE0, 13'h1FFF),
                    1'b1, flags(1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0)});
    plan.push_back({mk(jtbc_pkg::OP_CHECK, 32'h0, 4'd1, 1'b0, 1'b0, 32'h0, 13'd4),
                    1'b0, CLEAN});

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Items wait out the clearing sweep behind in_ready.
    foreach (plan[i]) send_item(plan[i].item, plan[i].given, plan[i].want);

    // Register settings: normal windows, a misaligned base, alignment zero with a
    // saturating trampoline, the top of the address space, empty regions both
    // ways, a limit far past the bitmap size, and a final phase without idling.
    run_phase(32'h0000_1000, 32'h0000_3000, 5'd31, 32'h0000_0100, 150, 20, 15);
    run_phase(32'h0000_0104, 32'h0000_2104, 5'd15, 32'h0000_0200, 150, 0, 0);
    run_phase(32'h0000_0080, 32'h0000_8000, 5'd0,  32'hFFFF_FFFF, 140, 35, 30);
    run_phase(32'hFFFF_0000, 32'hFFFF_FFFF, 5'd31, 32'h0000_0000, 130, 10, 20);
    run_phase(32'h0000_5000, 32'h0000_5000, 5'd10, 32'h0000_1000, 50, 25, 10);
    run_phase(32'h0000_0000, 32'hFFFF_FFFF, 5'd31, 32'h0001_0000, 150, 15, 25);
    run_phase(32'hFFFF_FFFF, 32'h0000_0000, 5'd15, 32'h0000_0040, 50, 20, 20);
    run_phase(32'h0000_0400, 32'h0000_1400, 5'd31, 32'h0000_0800, 220, 0, 0);

    drain();
    repeat (8) @(posedge clk);
    if (bad_count == 0 && flags_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
